// File: design/imh_pkg.sv
// shared types and constants for the indexed min-heap
`default_nettype none
package imh_pkg;
	localparam int CAPACITY    = 1024;
	localparam int MAX_HANDLES = 4096;

	localparam int VAL_W    = 30;
	localparam int FUNC_W   = 3;
	localparam int HANDLE_W = 13;
	localparam int CNT_W    = 11;
	localparam int SLOT_AW  = $clog2(CAPACITY);
	localparam int HND_AW   = $clog2(MAX_HANDLES);
	localparam int INS_W    = $clog2(MAX_HANDLES + 1);
	localparam int PW       = SLOT_AW + 2;

	localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_EXTRACT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CHANGE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [HND_AW-1:0] hidx;
	} entry_t;
endpackage
`default_nettype wire

// File: design/imh_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none
module imh_ram #(
	parameter int DW = 8,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: design/indexed_min_heap_top.sv
// indexed binary min-heap: request sequencer, shared compare unit and heap storage
//
// Input channel (in_valid/in_stall) carries one request: func, key_value, handle.
// Output channel (out_valid/out_stall) carries one result per request: status,
// taken_value, entry_count, min_value and is_empty after the request.
// A request is taken only when in_stall is low, which is while the sequencer is
// idle. The sequencer walks the heap one level at a time through a single compare
// unit and the slot memory read port, around the sift steps come lookup, final write and
// minimum read. The result sits in an output register; the next request is accepted
// while it waits, and the sequencer holds its following result until out_stall drops.
// Reset empties the heap and restarts handle numbering at 1; no memory sweep is
// needed, since a handle is live only when its slot is held and points back to it.
`default_nettype none
module indexed_min_heap_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [imh_pkg::FUNC_W-1:0]    func,
	input  wire logic [imh_pkg::VAL_W-1:0]     key_value,
	input  wire logic [imh_pkg::HANDLE_W-1:0]  handle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               status,
	output logic      [imh_pkg::VAL_W-1:0]     taken_value,
	output logic      [imh_pkg::CNT_W-1:0]     entry_count,
	output logic      [imh_pkg::VAL_W-1:0]     min_value,
	output logic                               is_empty
);
	typedef enum logic [3:0] {
		S_IDLE, S_TAKE, S_LAST, S_FIND, S_CHK, S_RISE, S_RISE_C,
		S_SINK, S_SINK_L, S_SINK_C, S_PUT, S_MIN, S_OUT
	} state_t;

	state_t                             state_q;
	logic [imh_pkg::FUNC_W-1:0]         func_q;
	logic [imh_pkg::VAL_W-1:0]          key_q;
	logic [imh_pkg::HND_AW-1:0]         hidx_q;
	logic [imh_pkg::SLOT_AW-1:0]        pos_q;
	logic [imh_pkg::SLOT_AW-1:0]        up_q;
	logic [imh_pkg::CNT_W-1:0]          fill_q;
	logic [imh_pkg::INS_W-1:0]          ins_q;
	imh_pkg::entry_t                    cur_q;
	imh_pkg::entry_t                    child_q;
	logic                               lsel_q;
	logic                               status_q;
	logic [imh_pkg::VAL_W-1:0]          taken_q;

	imh_pkg::entry_t                    slot_rdata;
	logic [imh_pkg::SLOT_AW-1:0]        slot_raddr;
	logic                               mv_we;
	imh_pkg::entry_t                    mv_entry;
	logic [imh_pkg::SLOT_AW-1:0]        hs_rdata;
	logic [imh_pkg::HND_AW-1:0]         hs_raddr;

	logic [imh_pkg::VAL_W-1:0]          cmp_a;
	logic [imh_pkg::VAL_W-1:0]          cmp_b;
	logic                               cmp_lt;

	logic [imh_pkg::PW-1:0]             left_w;
	logic [imh_pkg::PW-1:0]             right_w;
	logic                               left_in;
	logic                               right_in;
	logic [imh_pkg::SLOT_AW-1:0]        last_w;
	logic [imh_pkg::SLOT_AW-1:0]        up_w;
	logic                               accept;
	logic                               handle_bad;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign left_w   = {1'b0, pos_q, 1'b1};
	assign right_w  = left_w + 1'b1;
	assign left_in  = left_w < imh_pkg::PW'(fill_q);
	assign right_in = right_w < imh_pkg::PW'(fill_q);
	assign last_w   = imh_pkg::SLOT_AW'(fill_q - 1'b1);
	assign up_w     = (pos_q - 1'b1) >> 1;
	assign handle_bad = (handle == '0) || (32'(handle) > 32'(imh_pkg::MAX_HANDLES));
	assign hs_raddr = imh_pkg::HND_AW'(handle - 1'b1);

	// the one compare unit, shared by every sift step
	always_comb begin
		cmp_a = slot_rdata.value;
		cmp_b = cur_q.value;
		case (state_q)
			S_RISE_C: begin
				cmp_a = cur_q.value;
				cmp_b = slot_rdata.value;
			end
			S_SINK_C: begin
				cmp_b = lsel_q ? child_q.value : cur_q.value;
			end
			default: begin
			end
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	always_comb begin
		slot_raddr = '0;
		case (state_q)
			S_TAKE: slot_raddr = last_w;
			S_FIND: slot_raddr = hs_rdata;
			S_CHK:  slot_raddr = last_w;
			S_RISE: slot_raddr = up_w;
			S_SINK: slot_raddr = left_w[imh_pkg::SLOT_AW-1:0];
			S_SINK_L: slot_raddr = right_w[imh_pkg::SLOT_AW-1:0];
			default: slot_raddr = '0;
		endcase
	end

	// an entry moves into pos_q: a parent sliding down, a child moving up, or the carried one
	always_comb begin
		mv_we    = 1'b0;
		mv_entry = cur_q;
		case (state_q)
			S_RISE_C: begin
				mv_we    = cmp_lt;
				mv_entry = slot_rdata;
			end
			S_SINK_C: begin
				if (right_in && cmp_lt) begin
					mv_we    = 1'b1;
					mv_entry = slot_rdata;
				end else if (lsel_q) begin
					mv_we    = 1'b1;
					mv_entry = child_q;
				end
			end
			S_PUT: mv_we = 1'b1;
			default: begin
			end
		endcase
	end

	imh_ram #(
		.DW ($bits(imh_pkg::entry_t)),
		.AW (imh_pkg::SLOT_AW)
	) u_slot_ram (
		.clk   (clk),
		.we    (mv_we),
		.waddr (pos_q),
		.wdata (mv_entry),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	imh_ram #(
		.DW (imh_pkg::SLOT_AW),
		.AW (imh_pkg::HND_AW)
	) u_hslot_ram (
		.clk   (clk),
		.we    (mv_we),
		.waddr (mv_entry.hidx),
		.wdata (pos_q),
		.raddr (hs_raddr),
		.rdata (hs_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			ins_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q   <= func;
						key_q    <= key_value;
						hidx_q   <= hs_raddr;
						taken_q  <= '0;
						status_q <= imh_pkg::ST_OK;
						state_q  <= S_MIN;
						case (func)
							imh_pkg::FN_INSERT: begin
								if (fill_q >= imh_pkg::CNT_W'(imh_pkg::CAPACITY) ||
								    ins_q >= imh_pkg::INS_W'(imh_pkg::MAX_HANDLES)) begin
									status_q <= imh_pkg::ST_ERR;
								end else begin
									cur_q.value <= key_value;
									cur_q.hidx  <= imh_pkg::HND_AW'(ins_q);
									pos_q       <= imh_pkg::SLOT_AW'(fill_q);
									fill_q      <= fill_q + 1'b1;
									ins_q       <= ins_q + 1'b1;
									state_q     <= S_RISE;
								end
							end
							imh_pkg::FN_EXTRACT: begin
								if (fill_q == '0) begin
									status_q <= imh_pkg::ST_ERR;
								end else begin
									pos_q   <= '0;
									state_q <= S_TAKE;
								end
							end
							imh_pkg::FN_DELETE, imh_pkg::FN_CHANGE: begin
								if (handle_bad) begin
									status_q <= imh_pkg::ST_ERR;
								end else begin
									state_q <= S_FIND;
								end
							end
							imh_pkg::FN_CLEAR: fill_q <= '0;
							default: status_q <= imh_pkg::ST_ERR;
						endcase
					end
				end
				S_TAKE: begin
					taken_q <= slot_rdata.value;
					fill_q  <= fill_q - 1'b1;
					state_q <= (last_w == pos_q) ? S_MIN : S_LAST;
				end
				S_LAST: begin
					cur_q   <= slot_rdata;
					state_q <= S_RISE;
				end
				S_FIND: begin
					pos_q <= hs_rdata;
					if (imh_pkg::CNT_W'(hs_rdata) >= fill_q ||
					    imh_pkg::INS_W'(hidx_q) >= ins_q) begin
						status_q <= imh_pkg::ST_ERR;
						state_q  <= S_MIN;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (slot_rdata.hidx != hidx_q) begin
						status_q <= imh_pkg::ST_ERR;
						state_q  <= S_MIN;
					end else if (func_q == imh_pkg::FN_DELETE) begin
						fill_q  <= fill_q - 1'b1;
						state_q <= (last_w == pos_q) ? S_MIN : S_LAST;
					end else begin
						cur_q.value <= key_q;
						cur_q.hidx  <= hidx_q;
						state_q     <= S_RISE;
					end
				end
				S_RISE: begin
					up_q    <= up_w;
					state_q <= (pos_q == '0) ? S_SINK : S_RISE_C;
				end
				S_RISE_C: begin
					if (cmp_lt) begin
						pos_q   <= up_q;
						state_q <= S_RISE;
					end else begin
						state_q <= S_SINK;
					end
				end
				S_SINK: begin
					state_q <= left_in ? S_SINK_L : S_PUT;
				end
				S_SINK_L: begin
					child_q <= slot_rdata;
					lsel_q  <= cmp_lt;
					state_q <= S_SINK_C;
				end
				S_SINK_C: begin
					if (right_in && cmp_lt) begin
						pos_q   <= right_w[imh_pkg::SLOT_AW-1:0];
						state_q <= S_SINK;
					end else if (lsel_q) begin
						pos_q   <= left_w[imh_pkg::SLOT_AW-1:0];
						state_q <= S_SINK;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: state_q <= S_MIN;
				S_MIN: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						status      <= status_q;
						taken_value <= taken_q;
						entry_count <= fill_q;
						min_value   <= (fill_q == '0) ? '0 : slot_rdata.value;
						is_empty    <= (fill_q == '0);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= imh_pkg::CNT_W'(imh_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_ins_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ins_q >= $past(ins_q))
		else $error("handle numbering went backward");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)) &&
		(!is_empty || min_value == '0))
		else $error("empty flag disagrees with count or minimum");

	a_err_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == imh_pkg::ST_ERR |-> taken_value == '0)
		else $error("failed request reports a taken value");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(min_value))
		else $error("stalled result changed");
endmodule
`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the indexed min-heap: queue-fed driver, clocked monitor, heap predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import imh_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;

	typedef struct packed {
		logic [FUNC_W-1:0]   fn;
		logic [VAL_W-1:0]    key;
		logic [HANDLE_W-1:0] hnd;
	} request_t;

	typedef struct packed {
		logic             st;
		logic [VAL_W-1:0] taken;
		logic [CNT_W-1:0] cnt;
		logic [VAL_W-1:0] minv;
		logic             empty;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [VAL_W-1:0] key_value = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [VAL_W-1:0] taken_value;
	logic [CNT_W-1:0] entry_count;
	logic [VAL_W-1:0] min_value;
	logic is_empty;

	indexed_min_heap_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .key_value(key_value), .handle(handle),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.taken_value(taken_value), .entry_count(entry_count),
		.min_value(min_value), .is_empty(is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [VAL_W-1:0] hp_val [CAPACITY];
	int unsigned hp_hnd [CAPACITY];
	int unsigned hnd_pos [MAX_HANDLES];
	bit hnd_live [MAX_HANDLES];
	int unsigned hp_fill;
	int unsigned hp_ins;

	request_t pending_reqs[$];
	answer_t expected_answers[$];
	int unsigned errors = 0;
	int unsigned send_idle = 11;
	int unsigned recv_idle = 48;
	bit hold_send = 1'b0;
	int unsigned cycles = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [VAL_W-1:0] v;
		int unsigned h;
		v = hp_val[a]; h = hp_hnd[a];
		hp_val[a] = hp_val[b]; hp_hnd[a] = hp_hnd[b];
		hp_val[b] = v; hp_hnd[b] = h;
		hnd_pos[hp_hnd[a]] = a;
		hnd_pos[hp_hnd[b]] = b;
	endfunction

	function automatic int unsigned sift_up(int unsigned p);
		int unsigned up;
		while (p > 0) begin
			up = (p - 1) / 2;
			if (hp_val[up] <= hp_val[p]) break;
			swap_slots(p, up);
			p = up;
		end
		return p;
	endfunction

	function automatic void sift_down(int unsigned p);
		int unsigned l, r, best;
		forever begin
			l = 2 * p + 1; r = l + 1; best = p;
			if (l < hp_fill && hp_val[l] < hp_val[best]) best = l;
			if (r < hp_fill && hp_val[r] < hp_val[best]) best = r;
			if (best == p) break;
			swap_slots(p, best);
			p = best;
		end
	endfunction

	function automatic void drop_slot(int unsigned p);
		int unsigned last;
		last = hp_fill - 1;
		hnd_live[hp_hnd[p]] = 0;
		hp_fill = last;
		if (p != last) begin
			hp_val[p] = hp_val[last];
			hp_hnd[p] = hp_hnd[last];
			hnd_pos[hp_hnd[p]] = p;
			sift_down(sift_up(p));
		end
	endfunction

	function automatic bit lookup(input logic [HANDLE_W-1:0] h, output int unsigned p);
		p = 0;
		if (h == 0 || h > MAX_HANDLES) return 0;
		if (!hnd_live[h - 1]) return 0;
		p = hnd_pos[h - 1];
		return p < hp_fill;
	endfunction

	function automatic answer_t heap_predict(request_t rq);
		answer_t a;
		int unsigned p;
		a = '0;
		case (rq.fn)
			FN_INSERT: begin
				if (hp_fill >= CAPACITY || hp_ins >= MAX_HANDLES) a.st = ST_ERR;
				else begin
					hp_val[hp_fill] = rq.key;
					hp_hnd[hp_fill] = hp_ins;
					hnd_pos[hp_ins] = hp_fill;
					hnd_live[hp_ins] = 1;
					hp_ins++;
					hp_fill++;
					void'(sift_up(hp_fill - 1));
				end
			end
			FN_EXTRACT: begin
				if (hp_fill == 0) a.st = ST_ERR;
				else begin
					a.taken = hp_val[0];
					drop_slot(0);
				end
			end
			FN_DELETE: begin
				if (!lookup(rq.hnd, p)) a.st = ST_ERR;
				else drop_slot(p);
			end
			FN_CHANGE: begin
				if (!lookup(rq.hnd, p)) a.st = ST_ERR;
				else begin
					hp_val[p] = rq.key;
					sift_down(sift_up(p));
				end
			end
			FN_CLEAR: begin
				for (int unsigned i = 0; i < hp_fill; i++) hnd_live[hp_hnd[i]] = 0;
				hp_fill = 0;
			end
			default: a.st = ST_ERR;
		endcase
		a.cnt = hp_fill[CNT_W-1:0];
		a.minv = hp_fill ? hp_val[0] : '0;
		a.empty = (hp_fill == 0);
		return a;
	endfunction

	// driver: valid stays up across back-to-back requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && !hold_send &&
						$urandom_range(99) >= send_idle) begin
					request_t rq;
					rq = pending_reqs.pop_front();
					expected_answers.push_back(heap_predict(rq));
					in_valid <= 1'b1;
					func <= rq.fn;
					key_value <= rq.key;
					handle <= rq.hnd;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_idle);
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report("result with nothing expected", 32'(entry_count), 32'd0);
				end else begin
					answer_t w;
					w = expected_answers.pop_front();
					if (status !== w.st) report("status", status, w.st);
					if (taken_value !== w.taken) report("taken_value", taken_value, w.taken);
					if (entry_count !== w.cnt) report("entry_count", entry_count, w.cnt);
					if (min_value !== w.minv) report("min_value", min_value, w.minv);
					if (is_empty !== w.empty) report("is_empty", is_empty, w.empty);
				end
			end
		end
	end

	function automatic logic [VAL_W-1:0] rand_key();
		case ($urandom_range(3))
			0: return VAL_W'($urandom_range(15));
			1: return VAL_W'({VAL_W{1'b1}} - VAL_W'($urandom_range(3)));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic push_req(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] k, logic [HANDLE_W-1:0] h);
		request_t rq;
		rq.fn = f; rq.key = k; rq.hnd = h;
		pending_reqs.push_back(rq);
	endtask

	// mostly valid-looking requests against recent handles, some noise
	task automatic push_random(int unsigned n, int unsigned ins_bias);
		int unsigned issued;
		int unsigned r;
		logic [HANDLE_W-1:0] h;
		issued = 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			issued = hp_ins + pending_reqs.size();
			h = (issued > 0) ? HANDLE_W'(issued - $urandom_range(issued > 40 ? 40 : issued - 1))
				: HANDLE_W'(1);
			if ($urandom_range(9) == 0) h = HANDLE_W'($urandom);
			if (r < ins_bias) push_req(FN_INSERT, rand_key(), HANDLE_W'($urandom));
			else if (r < ins_bias + 15)
				push_req(FN_EXTRACT, VAL_W'($urandom), HANDLE_W'($urandom));
			else if (r < ins_bias + 30) push_req(FN_DELETE, VAL_W'($urandom), h);
			else if (r < ins_bias + 50) push_req(FN_CHANGE, rand_key(), h);
			else if (r < 98) push_req(FUNC_W'(FN_CLEAR +
				($urandom_range(1) ? 0 : $urandom_range(1, 3))), rand_key(), h);
			else push_req(FN_CLEAR, VAL_W'($urandom), HANDLE_W'($urandom));
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
		while (expected_answers.size() > 0) @(posedge clk);
	endtask

	initial begin
		hp_fill = 0;
		hp_ins = 0;
		for (int i = 0; i < MAX_HANDLES; i++) begin
			hnd_live[i] = 0;
			hnd_pos[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty errors, extremes, equal values, absent handles, unknown codes
		push_req(FN_EXTRACT, '1, '1);
		push_req(FN_DELETE, '0, 13'd1);
		push_req(FN_CHANGE, '1, 13'd0);
		push_req(FN_INSERT, '1, '1);
		push_req(FN_INSERT, '0, '0);
		push_req(FN_INSERT, 30'd5, 13'd0);
		push_req(FN_INSERT, 30'd5, 13'd0);
		push_req(FN_CHANGE, 30'd0, 13'd3);
		push_req(FN_CHANGE, '1, 13'd2);
		push_req(FN_DELETE, '0, 13'd4097);
		push_req(FN_DELETE, '0, '1);
		push_req(FN_DELETE, '0, 13'd4);
		push_req(FN_DELETE, '0, 13'd4);
		push_req(3'd5, '1, 13'd1);
		push_req(3'd6, '0, 13'd1);
		push_req(3'd7, '1, '1);
		push_req(FN_EXTRACT, '0, '0);
		push_req(FN_CLEAR, '0, '0);
		push_req(FN_CHANGE, 30'd1, 13'd1);
		push_req(FN_INSERT, 30'h2AAAAAAA, 13'h1555);
		push_req(FN_INSERT, 30'h15555555, 13'h0AAA);
		push_req(FN_EXTRACT, '0, '0);
		drain();

		// sender is held while the first random requests are queued, then released
		hold_send = 1'b1;
		push_random(10, 50);
		repeat (40) @(posedge clk);
		hold_send = 1'b0;
		push_random(300, 50);
		drain();

		send_idle = 48; recv_idle = 11;
		push_random(280, 35);
		drain();

		// fill to capacity, then overflow
		send_idle = 0; recv_idle = 0;
		for (int i = 0; i < CAPACITY + 3; i++)
			push_req(FN_INSERT, rand_key(), HANDLE_W'($urandom));
		push_random(60, 30);
		drain();
		push_req(FN_INSERT, 30'd7, 13'd0);
		push_random(40, 40);
		drain();

		repeat (100) @(posedge clk);
		if (errors == 0 && expected_answers.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
